/* hdl/bs64_pkg.sv */
// ----------------------------------------------------------------------------
// bs64_pkg
// shared types, constants and helper functions of the base64 stream decoder
// ----------------------------------------------------------------------------
package bs64_pkg;

   localparam int CHAR_W        = 8;
   localparam int BYTE_W        = 8;
   localparam int CAP_W         = 16;
   localparam int LEN_W         = 16;
   localparam int STATUS_W      = 3;
   localparam int SEXTET_W      = 6;
   localparam int GROUP_BYTES   = 3;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CAP_W-1:0] CAP_RESET   = 16'hffff;
   localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3d;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_CHAR  = 3'd1,
      ST_TRUNCATED = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_TRAILING  = 3'd4,
      ST_MISPLACED = 3'd5
   } status_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                         kind;
      logic [GROUP_BYTES*BYTE_W-1:0]    bytes;
      logic [1:0]                       count;
      status_type                       status;
      logic [LEN_W-1:0]                 length;
   } queue_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   // bit 6 set marks a character outside the alphabet
   function automatic logic [SEXTET_W:0] sextet_of(input logic [CHAR_W-1:0] c);
      logic [SEXTET_W:0] v;
      v = 7'h40;
      if (c >= 8'h41 && c <= 8'h5a) begin
         v = {1'b0, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         v = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2b) begin
         v = 7'd62;
      end else if (c == 8'h2f) begin
         v = 7'd63;
      end else if (c == CHAR_PAD) begin
         v = 7'd0;
      end
      return v;
   endfunction

endpackage

/* hdl/bs64_intf.sv */
// ----------------------------------------------------------------------------
// bs64 channel interfaces
// valid/ready channels for characters, results and the capacity register
// ----------------------------------------------------------------------------
interface bs64_req_if;
   import bs64_pkg::*;
   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   char_byte;
   logic                end_of_string;
   modport source (output valid, output char_byte, output end_of_string, input ready);
   modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

interface bs64_rsp_if;
   import bs64_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [BYTE_W-1:0]     data_byte;
   logic [STATUS_W-1:0]   status_code;
   logic [LEN_W-1:0]      decoded_length;
   logic                  last;
   modport source (output valid, output kind, output data_byte, output status_code,
                   output decoded_length, output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input status_code,
                   input decoded_length, input last, output ready);
endinterface

interface bs64_csr_if;
   import bs64_pkg::*;
   logic               valid;
   logic               ready;
   logic [CAP_W-1:0]   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hdl/bs64_front.sv */
// ----------------------------------------------------------------------------
// bs64_front
// accepts characters, tracks group and error state, queues groups and status
// ----------------------------------------------------------------------------
module bs64_front #(
   parameter int LENGTH_BITS = bs64_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   bs64_req_if.sink                    req,
   bs64_csr_if.sink                    csr,
   input  bs64_pkg::queue_status_type  q_status,
   output logic                        push,
   output bs64_pkg::queue_entry_type   push_entry
);
   import bs64_pkg::*;

   localparam int CMP_W = ((LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W) + 1;
   localparam int EXT_W = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;

   logic [CAP_W-1:0]        capacity_ff;
   logic [17:0]             sextets_ff, sextets_in;
   logic [1:0]              pos_ff, pos_in;
   logic [3:0]              pad_ff, pad_in;
   logic [LENGTH_BITS-1:0]  count_ff, count_in;
   logic                    padded_done_ff, padded_done_in;
   logic                    pad_err_ff, pad_err_in;
   status_type              error_ff, error_in;

   logic                    accept;
   logic                    is_pad;
   logic [SEXTET_W:0]       sext;
   logic [3:0]              pad_new;
   logic [1:0]              n_bytes;
   logic [CMP_W-1:0]        need;
   logic [EXT_W-1:0]        len_ext;
   status_type              end_status;

   assign csr.ready = 1'b1;
   assign req.ready = ~q_status.full;
   assign accept    = req.valid & req.ready;
   assign is_pad    = (req.char_byte == CHAR_PAD);
   assign sext      = sextet_of(req.char_byte);
   assign pad_new   = pad_ff | (4'(is_pad) << pos_ff);
   assign need      = CMP_W'(count_ff) + CMP_W'(GROUP_BYTES);
   assign len_ext   = EXT_W'(count_ff);

   always_comb begin
      if (pad_new[3]) begin
         n_bytes = pad_new[2] ? 2'd1 : 2'd2;
      end else begin
         n_bytes = 2'd3;
      end
      if (error_ff != ST_OK) begin
         end_status = error_ff;
      end else if (pos_ff != 2'd0) begin
         end_status = ST_TRUNCATED;
      end else if (pad_err_ff) begin
         end_status = ST_MISPLACED;
      end else begin
         end_status = ST_OK;
      end
   end

   always_comb begin
      sextets_in     = sextets_ff;
      pos_in         = pos_ff;
      pad_in         = pad_ff;
      count_in       = count_ff;
      padded_done_in = padded_done_ff;
      pad_err_in     = pad_err_ff;
      error_in       = error_ff;
      push           = 1'b0;
      push_entry.kind   = KIND_DATA;
      push_entry.bytes  = {sextets_ff[17:12], sextets_ff[11:10],
                           sextets_ff[9:6], sextets_ff[5:2],
                           sextets_ff[1:0], sext[SEXTET_W-1:0]};
      push_entry.count  = n_bytes;
      push_entry.status = end_status;
      push_entry.length = len_ext[LEN_W-1:0];
      if (accept) begin
         if (req.end_of_string) begin
            push            = 1'b1;
            push_entry.kind = KIND_STATUS;
            sextets_in      = '0;
            pos_in          = '0;
            pad_in          = '0;
            count_in        = '0;
            padded_done_in  = 1'b0;
            pad_err_in      = 1'b0;
            error_in        = ST_OK;
         end else if (error_ff != ST_OK || is_blank(req.char_byte)) begin
            error_in = error_ff;
         end else if (padded_done_ff) begin
            error_in = ST_TRAILING;
         end else if (sext[SEXTET_W]) begin
            error_in = ST_BAD_CHAR;
         end else if (pos_ff != 2'd3) begin
            pad_in     = pad_new;
            sextets_in = {sextets_ff[11:0], sext[SEXTET_W-1:0]};
            pos_in     = pos_ff + 2'd1;
         end else if (need > CMP_W'(capacity_ff)) begin
            pad_in   = pad_new;
            error_in = ST_OVERFLOW;
         end else begin
            push = 1'b1;
            if (pad_new != 4'd0) begin
               padded_done_in = 1'b1;
               if (pad_new[1:0] != 2'b00 || pad_new[3:2] == 2'b01) begin
                  pad_err_in = 1'b1;
               end
            end
            count_in   = count_ff + LENGTH_BITS'(n_bytes);
            sextets_in = '0;
            pos_in     = '0;
            pad_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= CAP_RESET;
         sextets_ff     <= '0;
         pos_ff         <= '0;
         pad_ff         <= '0;
         count_ff       <= '0;
         padded_done_ff <= 1'b0;
         pad_err_ff     <= 1'b0;
         error_ff       <= ST_OK;
      end else begin
         if (csr.valid) begin
            capacity_ff <= csr.data;
         end
         sextets_ff     <= sextets_in;
         pos_ff         <= pos_in;
         pad_ff         <= pad_in;
         count_ff       <= count_in;
         padded_done_ff <= padded_done_in;
         pad_err_ff     <= pad_err_in;
         error_ff       <= error_in;
      end
   end

endmodule

/* hdl/bs64_queue.sv */
// ----------------------------------------------------------------------------
// bs64_queue
// short queue of decoded groups and status entries between front and back
// ----------------------------------------------------------------------------
module bs64_queue #(
   parameter int DEPTH = bs64_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bs64_pkg::queue_entry_type   push_entry,
   input  logic                        pop,
   output bs64_pkg::queue_entry_type   head,
   output bs64_pkg::queue_status_type  status
);
   import bs64_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type     slots_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic                do_push, do_pop;

   assign status.empty = (fill_ff == CNT_W'(0));
   assign status.full  = (fill_ff == CNT_W'(DEPTH));
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head         = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* hdl/bs64_back.sv */
// ----------------------------------------------------------------------------
// bs64_back
// expands queue entries to one registered result per cycle while rsp is ready
// ----------------------------------------------------------------------------
module bs64_back (
   input  logic                        clock,
   input  logic                        reset,
   input  bs64_pkg::queue_entry_type   head,
   input  bs64_pkg::queue_status_type  q_status,
   output logic                        pop,
   bs64_rsp_if.source                  rsp
);
   import bs64_pkg::*;

   logic [1:0]           idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   logic                 kind_ff, kind_in;
   logic [BYTE_W-1:0]    data_ff, data_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [LEN_W-1:0]     length_ff, length_in;
   logic                 last_ff, last_in;
   logic                 load, emit, is_last;
   logic [BYTE_W-1:0]    sel_byte;

   assign load = ~valid_ff | rsp.ready;
   assign emit = load & ~q_status.empty;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head.bytes[3*BYTE_W-1:2*BYTE_W];
         2'd1:    sel_byte = head.bytes[2*BYTE_W-1:BYTE_W];
         default: sel_byte = head.bytes[BYTE_W-1:0];
      endcase
      is_last = (head.kind == KIND_STATUS) || (idx_ff == head.count - 2'd1);
   end

   always_comb begin
      valid_in  = valid_ff;
      kind_in   = kind_ff;
      data_in   = data_ff;
      status_in = status_ff;
      length_in = length_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = emit;
      end
      if (emit) begin
         last_in = is_last;
         if (head.kind == KIND_STATUS) begin
            kind_in   = 1'b1;
            data_in   = '0;
            status_in = head.status;
            length_in = head.length;
         end else begin
            kind_in   = 1'b0;
            data_in   = sel_byte;
            status_in = ST_OK;
            length_in = '0;
         end
         pop    = is_last;
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      length_ff <= length_in;
      last_ff   <= last_in;
   end

   assign rsp.valid          = valid_ff;
   assign rsp.kind           = kind_ff;
   assign rsp.data_byte      = data_ff;
   assign rsp.status_code    = status_ff;
   assign rsp.decoded_length = length_ff;
   assign rsp.last           = last_ff;

endmodule

/* hdl/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 decoder, one character per transaction, status on end
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_ch    in         char_byte, end_of_string
//  rsp_ch    out        kind, data_byte, status_code, decoded_length, last
//  csr_ch    in         capacity (16 bit), always ready
//
//  one character per cycle unless the queue is full; a group's bytes and a
//  status leave one per cycle while rsp_ch is ready
//  req_ch.ready drops only while the group queue between front and back is full
//  synchronous reset clears string state and sets capacity to 65535
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
   parameter int LENGTH_BITS = bs64_pkg::LENGTH_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = bs64_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   bs64_req_if.sink     req_ch,
   bs64_rsp_if.source   rsp_ch,
   bs64_csr_if.sink     csr_ch
);
   import bs64_pkg::*;

   logic               push, pop;
   queue_entry_type    push_entry, head;
   queue_status_type   q_status;

   bs64_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .csr        (csr_ch),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   bs64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   bs64_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

endmodule

/* tb/sv/bs64_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs64_result_checker
// watches the character, result and capacity channels of the base64 stream
// decoder, decodes every accepted character transaction on its own and
// compares each accepted result field by field with the oldest one due
// ----------------------------------------------------------------------------
module bs64_result_checker (
   input  logic   clock,
   input  logic   reset,
   bs64_req_if    req_ch,
   bs64_rsp_if    rsp_ch,
   bs64_csr_if    csr_ch,
   output int     failures,
   output int     outstanding
);
   import bs64_pkg::*;

   typedef struct packed {
      kind_type           kind;
      logic [BYTE_W-1:0]  data;
      status_type         status;
      logic [LEN_W-1:0]   length;
      logic               last;
   } decoder_result_type;

   string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic [SEXTET_W:0]     sextet_lut [256];
   decoder_result_type    results_due[$];
   int                    mismatch_count = 0;

   logic [CAP_W-1:0]      capacity;
   logic [17:0]           sextets;
   logic [1:0]            slot;
   logic [3:0]            pads;
   logic [LEN_W-1:0]      emitted;
   logic                  pad_group_seen;
   logic                  pad_misplaced;
   status_type            first_error;

   assign failures = mismatch_count;

   initial begin
      foreach (sextet_lut[i]) sextet_lut[i] = 7'h40;
      for (int i = 0; i < 64; i++) sextet_lut[alphabet[i]] = 7'(i);
      sextet_lut[CHAR_PAD] = 7'h00;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 30)
         $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   function automatic void clear_string();
      sextets        = '0;
      slot           = '0;
      pads           = '0;
      emitted        = '0;
      pad_group_seen = 1'b0;
      pad_misplaced  = 1'b0;
      first_error    = ST_OK;
   endfunction

   function automatic void push_result(input kind_type kind, input logic [7:0] data,
                                       input status_type status,
                                       input logic [LEN_W-1:0] length, input logic last);
      decoder_result_type r;
      r.kind   = kind;
      r.data   = data;
      r.status = status;
      r.length = length;
      r.last   = last;
      results_due.push_back(r);
   endfunction

   function automatic void decode_char(input logic [7:0] c, input logic eos);
      status_type        st;
      logic [SEXTET_W:0] v;
      logic [23:0]       word;
      int                n;
      if (eos) begin
         st = first_error;
         if (st == ST_OK) begin
            if (slot != 2'd0) st = ST_TRUNCATED;
            else if (pad_misplaced) st = ST_MISPLACED;
         end
         push_result(KIND_STATUS, 8'h00, st, emitted, 1'b1);
         clear_string();
         return;
      end
      if (first_error != ST_OK || c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]}) return;
      if (pad_group_seen) begin
         first_error = ST_TRAILING;
         return;
      end
      v = sextet_lut[c];
      if (v[SEXTET_W]) begin
         first_error = ST_BAD_CHAR;
         return;
      end
      if (c == CHAR_PAD) pads[slot] = 1'b1;
      if (slot != 2'd3) begin
         sextets = {sextets[11:0], v[5:0]};
         slot    = slot + 2'd1;
         return;
      end
      if ({1'b0, emitted} + 17'd3 > {1'b0, capacity}) begin
         first_error = ST_OVERFLOW;
         return;
      end
      word = {sextets, v[5:0]};
      n = pads[3] ? (pads[2] ? 1 : 2) : 3;
      if (pads != 4'b0000) begin
         pad_group_seen = 1'b1;
         if (pads[1:0] != 2'b00 || pads[3:2] == 2'b01) pad_misplaced = 1'b1;
      end
      for (int k = 0; k < n; k++)
         push_result(KIND_DATA, word[23 - 8*k -: 8], ST_OK, '0, k == n - 1);
      emitted = emitted + LEN_W'(n);
      sextets = '0;
      slot    = '0;
      pads    = '0;
   endfunction

   always @(posedge clock) begin
      decoder_result_type want;
      if (reset) begin
         capacity = CAP_RESET;
         clear_string();
         results_due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (results_due.size() == 0) begin
               report_mismatch("result transaction with nothing due", rsp_ch.data_byte, 0);
            end else begin
               want = results_due.pop_front();
               if (rsp_ch.kind !== want.kind)
                  report_mismatch("kind", rsp_ch.kind, want.kind);
               if (rsp_ch.data_byte !== want.data)
                  report_mismatch("data_byte", rsp_ch.data_byte, want.data);
               if (rsp_ch.status_code !== want.status)
                  report_mismatch("status_code", rsp_ch.status_code, want.status);
               if (rsp_ch.decoded_length !== want.length)
                  report_mismatch("decoded_length", rsp_ch.decoded_length, want.length);
               if (rsp_ch.last !== want.last)
                  report_mismatch("last", rsp_ch.last, want.last);
            end
         end
         if (csr_ch.valid && csr_ch.ready) capacity = csr_ch.data;
         if (req_ch.valid && req_ch.ready)
            decode_char(req_ch.char_byte, req_ch.end_of_string);
      end
      outstanding <= results_due.size();
   end

endmodule

/* tb/sv/base64_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// drives directed and random base64 strings with random gaps and stalls on
// both channels, changes the output capacity between strings, and leaves
// prediction and comparison to the result checker
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;
   import bs64_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int STALL_CYCLES  = 300;
   localparam int RANDOM_ITEMS  = 260;

   string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic clock;
   logic reset;
   int   failures;
   int   outstanding;
   int   cycles = 0;
   int   items_sent = 0;
   bit   tx_idle = 1'b1;
   bit   rx_idle = 1'b1;
   bit   rx_stall_req = 1'b0;

   bs64_req_if req_ch ();
   bs64_rsp_if rsp_ch ();
   bs64_csr_if csr_ch ();

   base64_stream_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   bs64_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("base64_stream_decoder test failed");
         $finish;
      end
   end

   task automatic send_item(input logic [7:0] c, input logic eos);
      int gap;
      gap = tx_idle ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.char_byte     <= c;
      req_ch.end_of_string <= eos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic end_string();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
      end_string();
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_random_string();
      logic [7:0] text[$];
      int         groups;
      int         pad;
      int         pos;
      groups = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 5);
      pad = $urandom_range(0, 1) ? 0 : $urandom_range(1, 2);
      for (int g = 0; g < groups; g++)
         for (int k = 0; k < 4; k++)
            text.push_back((g == groups - 1 && k >= 4 - pad) ? CHAR_PAD
                                                            : alphabet[$urandom_range(0, 63)]);
      pos = $urandom_range(0, text.size());
      // mostly well-formed, the rest broken in one way
      case ($urandom_range(0, 9))
         0: text.insert(pos, 8'($urandom_range(0, 255)));
         1: text.insert(pos, CHAR_PAD);
         2: if (text.size() != 0) text.delete($urandom_range(0, text.size() - 1));
         3: text.push_back(alphabet[$urandom_range(0, 63)]);
         default: ;
      endcase
      foreach (text[i]) begin
         if ($urandom_range(0, 9) == 0)
            send_item($urandom_range(0, 1) ? CHAR_SPACE : 8'($urandom_range(CHAR_TAB, CHAR_CR)),
                      1'b0);
         send_item(text[i], 1'b0);
      end
      end_string();
   endtask

   initial begin : result_sink
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_stall_req) begin
            rx_stall_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
         end
         gap = rx_idle ? $urandom_range(0, 13) : 0;
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int  target;
      int  next_cfg;
      bit  stall_done;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.char_byte     <= '0;
      req_ch.end_of_string <= 1'b0;
      csr_ch.valid         <= 1'b0;
      csr_ch.data          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty string, bad characters, padding forms, trailing data, truncation
      end_string();
      send_item(8'hff, 1'b0);
      end_string();
      send_string("/+9z \tTWE=\r");
      send_string("TQ==A");
      send_string("A=AA");
      send_string("TW");

      // overflow at zero capacity and after one group
      write_capacity(16'h0000);
      send_string("AAAA");
      write_capacity(16'd3);
      send_string("AAAAAAAA");
      write_capacity(16'hffff);

      target     = items_sent + RANDOM_ITEMS;
      next_cfg   = items_sent + 70;
      stall_done = 1'b0;
      while (items_sent < target) begin
         if (items_sent >= next_cfg) begin
            case ($urandom_range(0, 3))
               0: write_capacity(16'($urandom_range(0, 12)));
               1: write_capacity(16'hffff);
               2: write_capacity(16'($urandom_range(0, 65535)));
               default: write_capacity(16'($urandom_range(3, 30)));
            endcase
            next_cfg += 70;
         end
         if (!stall_done && items_sent >= target - 160) begin
            // long result hold-off while characters keep coming
            write_capacity(16'hffff);
            tx_idle      = 1'b0;
            rx_idle      = 1'b0;
            rx_stall_req = 1'b1;
            for (int i = 0; i < 48; i++) send_item(alphabet[$urandom_range(0, 63)], 1'b0);
            end_string();
            stall_done = 1'b1;
         end
         tx_idle = ($urandom_range(0, 3) != 0);
         rx_idle = ($urandom_range(0, 3) != 0);
         send_random_string();
      end

      wait_drained();
      repeat (12) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("base64_stream_decoder test passed");
      else
         $display("base64_stream_decoder test failed");
      $finish;
   end

endmodule
